[design/lru_page_buffer_allocator_macros.svh]
// Assertion macros for the LRU page buffer allocator.
// Used by the top level; no other dependencies.
`ifndef LRU_PAGE_BUFFER_ALLOCATOR_MACROS_SVH
`define LRU_PAGE_BUFFER_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define LPBA_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("lpba assertion failed");
// Next-cycle implication, disabled during reset.
`define LPBA_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("lpba assertion failed");
`else
`define LPBA_ASSERT_IMP(label, clk, rst_n, a, b)
`define LPBA_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

[design/lpba_pkg.sv]
// Shared types and constants for the LRU page buffer allocator.
// No dependencies.
`default_nettype none
package lpba_pkg;

  localparam int MAX_PAGES = 16;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int TBL_W     = 8;
  localparam int BLK_W     = 32;
  localparam int LEN_W     = 16;
  localparam int PSIZE_W   = 16;
  localparam int PIU_W     = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 56;
  localparam int OUT_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd1;

  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST    = 16'd1024;
  localparam logic [PIU_W-1:0]   PAGES_IN_USE_RST = 5'd16;

  typedef enum logic [1:0] {
    STAT_FREE     = 2'd0,
    STAT_REPLACED = 2'd1,
    STAT_HIT      = 2'd2,
    STAT_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_t;

  typedef enum logic [1:0] {
    REC_NONE,
    REC_APPEND,
    REC_PROMOTE
  } rec_op_t;

  // Control from the sequencer to the recency list
  typedef struct packed {
    rec_op_t                op;
    logic [PAGE_W-1:0]      pos;
    logic [CNT_W-1:0]       fill;
  } rec_ctl_t;

  // Write request into the tag store
  typedef struct packed {
    logic                   we;
    logic [PAGE_W-1:0]      addr;
    logic [TBL_W-1:0]       tbl;
    logic [BLK_W-1:0]       blk;
  } tag_wr_t;

endpackage
`default_nettype wire

[design/lru_page_buffer_allocator.sv]
// LRU page buffer allocator top level: sequencer, config registers, result register.
// Depends on lpba_pkg, lpba_tag_store, lpba_recency and the assertion macro header.
//
// Usage:
//   Input channel in_*: one request per accepted beat, carrying table id, block number
//   and content length. Output channel out_*: exactly one result per request, with a
//   status code and the page number that now holds the block.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (0 page_size,
//   1 pages_in_use); write only while no request is outstanding.
//   Search: a too-long request, or any request into an empty pool, skips the tag
//   search and goes straight to the update state. Otherwise the tag search walks the
//   recency list one page per cycle through a single tag comparator, stopping at the
//   first match or at the last filled position, so at most 16 pages are examined.
//   in_tready is high only while the sequencer is idle.
//   The result sits in an output register; the next request is accepted and
//   searched while it waits, but is not committed until that result is taken.
//   Reset: page_size returns to 1024, pages_in_use to 16, and the pool is emptied
//   (fill count zero); tag and recency contents are left as they are.
`default_nettype none
`include "lru_page_buffer_allocator_macros.svh"
module lru_page_buffer_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] table_id, [39:8] block_number, [55:40] content_length
  input  wire logic [lpba_pkg::IN_W-1:0]         in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [1:0] status, [5:2] page_number, [7:6] zero
  output logic [lpba_pkg::OUT_W-1:0]             out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [lpba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lpba_pkg::CFG_W-1:0]        cfg_wdata
);

  lpba_pkg::state_t state_r, state_nxt;

  logic [lpba_pkg::PSIZE_W-1:0] page_size_r;
  logic [lpba_pkg::PIU_W-1:0]   pages_in_use_r;
  logic [lpba_pkg::CNT_W-1:0]   fill_r;
  logic [lpba_pkg::CNT_W-1:0]   pos_r;
  logic                         hit_r;
  logic                         too_long_r;
  logic [lpba_pkg::TBL_W-1:0]   req_tbl_r;
  logic [lpba_pkg::BLK_W-1:0]   req_blk_r;
  logic                         out_valid_r;
  lpba_pkg::status_t            out_status_r;
  logic [lpba_pkg::PAGE_W-1:0]  out_page_r;

  logic [lpba_pkg::TBL_W-1:0]   in_tbl;
  logic [lpba_pkg::BLK_W-1:0]   in_blk;
  logic [lpba_pkg::LEN_W-1:0]   in_len;
  logic                         in_accept;
  logic                         in_too_long;
  logic                         match;
  logic                         search_last;
  logic                         commit;
  logic                         out_free;
  logic [lpba_pkg::CNT_W-1:0]   capacity;
  logic                         pool_full;
  logic [lpba_pkg::PAGE_W-1:0]  rd_page;
  lpba_pkg::status_t            res_status;
  logic [lpba_pkg::PAGE_W-1:0]  res_page;
  lpba_pkg::rec_ctl_t           rec_ctl;
  lpba_pkg::tag_wr_t            tag_wr;

  assign in_tbl = in_tdata[7:0];
  assign in_blk = in_tdata[39:8];
  assign in_len = in_tdata[55:40];

  assign in_accept   = in_tvalid && in_tready;
  assign in_too_long = in_len > page_size_r;
  assign search_last = (pos_r == fill_r - lpba_pkg::CNT_W'(1));
  assign out_free    = !out_valid_r || out_tready;

  // Effective pool size: zero acts as one, clamp at the built size
  always_comb begin
    priority if (pages_in_use_r == '0) begin
      capacity = lpba_pkg::CNT_W'(1);
    end else if (pages_in_use_r > lpba_pkg::PIU_W'(lpba_pkg::MAX_PAGES)) begin
      capacity = lpba_pkg::CNT_W'(lpba_pkg::MAX_PAGES);
    end else begin
      capacity = lpba_pkg::CNT_W'(pages_in_use_r);
    end
  end
  assign pool_full = fill_r >= capacity;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpba_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_too_long || fill_r == '0) ? lpba_pkg::S_UPDATE
                                                    : lpba_pkg::S_SEARCH;
        end
      end
      lpba_pkg::S_SEARCH: begin
        if (match || search_last) state_nxt = lpba_pkg::S_UPDATE;
      end
      lpba_pkg::S_UPDATE: begin
        if (out_free) state_nxt = lpba_pkg::S_IDLE;
      end
      default: state_nxt = lpba_pkg::S_IDLE;
    endcase
  end

  // Output and control decode
  always_comb begin
    in_tready  = 1'b0;
    commit     = 1'b0;
    res_status = lpba_pkg::STAT_TOO_LONG;
    res_page   = '0;
    rec_ctl.op   = lpba_pkg::REC_NONE;
    rec_ctl.pos  = pos_r[lpba_pkg::PAGE_W-1:0];
    rec_ctl.fill = fill_r;
    tag_wr.we   = 1'b0;
    tag_wr.addr = fill_r[lpba_pkg::PAGE_W-1:0];
    tag_wr.tbl  = req_tbl_r;
    tag_wr.blk  = req_blk_r;
    unique case (state_r)
      lpba_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      lpba_pkg::S_SEARCH: ;
      lpba_pkg::S_UPDATE: begin
        commit = out_free;
        priority if (too_long_r) begin
          res_status = lpba_pkg::STAT_TOO_LONG;
        end else if (hit_r) begin
          // hit: promote the matched position
          res_status = lpba_pkg::STAT_HIT;
          res_page   = rd_page;
          if (out_free) rec_ctl.op = lpba_pkg::REC_PROMOTE;
        end else if (!pool_full) begin
          // miss with a never-used page left: take the next one
          res_status = lpba_pkg::STAT_FREE;
          res_page   = fill_r[lpba_pkg::PAGE_W-1:0];
          tag_wr.we  = out_free;
          if (out_free) rec_ctl.op = lpba_pkg::REC_APPEND;
        end else begin
          // miss with a full pool: evict the least recent page
          res_status  = lpba_pkg::STAT_REPLACED;
          rec_ctl.pos = '0;
          res_page    = rd_page;
          tag_wr.we   = out_free;
          tag_wr.addr = rd_page;
          if (out_free) rec_ctl.op = lpba_pkg::REC_PROMOTE;
        end
      end
      default: ;
    endcase
  end

  lpba_tag_store u_tags (
    .clk     (clk),
    .wr      (tag_wr),
    .rd_page (rd_page),
    .req_tbl (req_tbl_r),
    .req_blk (req_blk_r),
    .match   (match)
  );

  lpba_recency u_recency (
    .clk     (clk),
    .ctl     (rec_ctl),
    .rd_page (rd_page)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lpba_pkg::S_IDLE;
      page_size_r    <= lpba_pkg::PAGE_SIZE_RST;
      pages_in_use_r <= lpba_pkg::PAGES_IN_USE_RST;
      fill_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          lpba_pkg::CFG_PAGE_SIZE:    page_size_r    <= cfg_wdata[lpba_pkg::PSIZE_W-1:0];
          lpba_pkg::CFG_PAGES_IN_USE: pages_in_use_r <= cfg_wdata[lpba_pkg::PIU_W-1:0];
          default: ;
        endcase
      end
      if (commit && res_status == lpba_pkg::STAT_FREE) begin
        fill_r <= fill_r + lpba_pkg::CNT_W'(1);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_tbl_r  <= in_tbl;
      req_blk_r  <= in_blk;
      too_long_r <= in_too_long;
      hit_r      <= 1'b0;
      pos_r      <= '0;
    end else if (state_r == lpba_pkg::S_SEARCH) begin
      // hold the position on a match or at the last filled position, otherwise advance
      if (match) begin
        hit_r <= 1'b1;
      end else if (!search_last) begin
        pos_r <= pos_r + lpba_pkg::CNT_W'(1);
      end
    end
    if (commit) begin
      out_status_r <= res_status;
      out_page_r   <= res_page;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_page_r, out_status_r};

  `LPBA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_accept, !in_tready)
  `LPBA_ASSERT_IMP(a_fill_bounded, clk, rst_n, 1'b1, fill_r <= lpba_pkg::CNT_W'(lpba_pkg::MAX_PAGES))
  `LPBA_ASSERT_NXT(a_free_grows_fill, clk, rst_n, commit && res_status == lpba_pkg::STAT_FREE, fill_r == $past(fill_r) + lpba_pkg::CNT_W'(1))
  `LPBA_ASSERT_IMP(a_commit_needs_room, clk, rst_n, commit, !out_valid_r || out_tready)

endmodule
`default_nettype wire

[design/lpba_tag_store.sv]
// Per-page tag registers with one shared tag comparator.
// Depends on lpba_pkg.
`default_nettype none
module lpba_tag_store (
  input  wire logic                         clk,
  input  wire lpba_pkg::tag_wr_t            wr,
  input  wire logic [lpba_pkg::PAGE_W-1:0]  rd_page,
  input  wire logic [lpba_pkg::TBL_W-1:0]   req_tbl,
  input  wire logic [lpba_pkg::BLK_W-1:0]   req_blk,
  output logic                              match
);

  logic [lpba_pkg::TBL_W-1:0] tbl_r [lpba_pkg::MAX_PAGES];
  logic [lpba_pkg::BLK_W-1:0] blk_r [lpba_pkg::MAX_PAGES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      tbl_r[wr.addr] <= wr.tbl;
      blk_r[wr.addr] <= wr.blk;
    end
  end

  // Shared comparator: one page checked per cycle
  assign match = (tbl_r[rd_page] == req_tbl) && (blk_r[rd_page] == req_blk);

endmodule
`default_nettype wire

[design/lpba_recency.sv]
// Recency list: page numbers from least (position 0) to most recently used.
// Depends on lpba_pkg.
`default_nettype none
module lpba_recency (
  input  wire logic                          clk,
  input  wire lpba_pkg::rec_ctl_t            ctl,
  output logic [lpba_pkg::PAGE_W-1:0]        rd_page
);

  logic [lpba_pkg::PAGE_W-1:0] rec_r   [lpba_pkg::MAX_PAGES];
  logic [lpba_pkg::PAGE_W-1:0] rec_nxt [lpba_pkg::MAX_PAGES];
  logic [lpba_pkg::CNT_W-1:0]  last;

  assign rd_page = rec_r[ctl.pos];
  assign last    = ctl.fill - lpba_pkg::CNT_W'(1);

  always_comb begin
    for (int i = 0; i < lpba_pkg::MAX_PAGES; i++) begin
      rec_nxt[i] = rec_r[i];
      unique case (ctl.op)
        lpba_pkg::REC_APPEND: begin
          if (lpba_pkg::CNT_W'(i) == ctl.fill) rec_nxt[i] = ctl.fill[lpba_pkg::PAGE_W-1:0];
        end
        lpba_pkg::REC_PROMOTE: begin
          // shift the tail down by one, put the promoted page at the top
          if (lpba_pkg::CNT_W'(i) == last) begin
            rec_nxt[i] = rd_page;
          end else if (i < lpba_pkg::MAX_PAGES - 1 &&
                       lpba_pkg::CNT_W'(i) >= {1'b0, ctl.pos} &&
                       lpba_pkg::CNT_W'(i) < last) begin
            rec_nxt[i] = rec_r[(i + 1) % lpba_pkg::MAX_PAGES];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lpba_pkg::MAX_PAGES; i++) begin
      rec_r[i] <= rec_nxt[i];
    end
  end

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking bench for lru_page_buffer_allocator: directed table, then random phases.
// Needs lpba_pkg and the allocator RTL; typed rows or an in-bench LRU model check each result.
module testbench;

  localparam int STUCK_LIMIT  = 3000;  // cycles with no handshake on either side
  localparam int SETTLE       = 40;    // margin beyond the worst-case search
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 241;
  localparam int TAG_POOL     = 20;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    lpba_pkg::status_t           status;
    logic [lpba_pkg::PAGE_W-1:0] page;
  } alloc_t;

  typedef struct {
    bit                             is_cfg;
    logic [lpba_pkg::CFG_IDX_W-1:0] idx;
    logic [lpba_pkg::CFG_W-1:0]     val;
    logic [lpba_pkg::TBL_W-1:0]     tbl;
    logic [lpba_pkg::BLK_W-1:0]     blk;
    logic [lpba_pkg::LEN_W-1:0]     len;
    bit                             typed;
    alloc_t                         res;
  } plan_row_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [lpba_pkg::IN_W-1:0]      in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lpba_pkg::OUT_W-1:0]     out_tdata;
  logic                           cfg_we     = 1'b0;
  logic [lpba_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [lpba_pkg::CFG_W-1:0]     cfg_wdata  = '0;

  always #10 clk = ~clk;

  lru_page_buffer_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] table_id, [39:8] block_number, [55:40] content_length
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [1:0] status, [5:2] page_number, [7:6] zero
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // LRU pool model: its own copy of the tags, the recency list and the registers.
  // ---------------------------------------------------------------------------
  logic [lpba_pkg::PSIZE_W-1:0] page_size_q;
  logic [lpba_pkg::PIU_W-1:0]   pool_size_q;
  int                           pages_taken;
  logic [lpba_pkg::TBL_W-1:0]   page_tbl  [lpba_pkg::MAX_PAGES];
  logic [lpba_pkg::BLK_W-1:0]   page_blk  [lpba_pkg::MAX_PAGES];
  logic [lpba_pkg::PAGE_W-1:0]  lru_order [lpba_pkg::MAX_PAGES];   // index 0 is least recent

  alloc_t pending_allocs[$];   // results still owed by the block, oldest first

  // Append a result the block now owes.
  function automatic void owe_result(alloc_t a);
    pending_allocs.insert(pending_allocs.size(), a);
  endfunction

  // Remove and return the oldest owed result.
  function automatic alloc_t take_owed();
    alloc_t a;
    a = pending_allocs[0];
    pending_allocs.delete(0);
    return a;
  endfunction

  // Move the recency entry at pos to the most recent end, closing the gap.
  function automatic void move_to_mru(int pos);
    logic [lpba_pkg::PAGE_W-1:0] pg;
    pg = lru_order[pos];
    for (int i = pos; i + 1 < pages_taken; i++) lru_order[i] = lru_order[i + 1];
    lru_order[pages_taken - 1] = pg;
  endfunction

  function automatic alloc_t allocate_page(logic [lpba_pkg::TBL_W-1:0] tbl,
                                           logic [lpba_pkg::BLK_W-1:0] blk,
                                           logic [lpba_pkg::LEN_W-1:0] len);
    alloc_t r;
    int     cap;
    int     hit_pos;
    cap     = int'(pool_size_q);
    hit_pos = -1;
    if (cap < 1) cap = 1;
    if (cap > lpba_pkg::MAX_PAGES) cap = lpba_pkg::MAX_PAGES;
    // Reject oversize content without touching any state.
    if (len > page_size_q) begin
      r.status = lpba_pkg::STAT_TOO_LONG;
      r.page   = '0;
      return r;
    end
    // Lookup covers every page taken so far, even if the pool was shrunk below that.
    for (int pos = 0; pos < pages_taken; pos++) begin
      if (hit_pos < 0 && page_tbl[lru_order[pos]] == tbl && page_blk[lru_order[pos]] == blk)
        hit_pos = pos;
    end
    if (hit_pos >= 0) begin
      r.status = lpba_pkg::STAT_HIT;
      r.page   = lru_order[hit_pos];
      move_to_mru(hit_pos);
    end else if (pages_taken < cap) begin
      r.status              = lpba_pkg::STAT_FREE;
      r.page                = lpba_pkg::PAGE_W'(pages_taken);
      page_tbl[r.page]      = tbl;
      page_blk[r.page]      = blk;
      lru_order[pages_taken] = r.page;
      pages_taken++;
    end else begin
      r.status         = lpba_pkg::STAT_REPLACED;
      r.page           = lru_order[0];
      page_tbl[r.page] = tbl;
      page_blk[r.page] = blk;
      move_to_mru(0);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_max    = 6;
  int sent_count = 0;
  int cfg_writes = 0;

  // Offer one request, hold it until accepted, then log what the block owes for it.
  task automatic offer_request(input logic [lpba_pkg::TBL_W-1:0] tbl,
                               input logic [lpba_pkg::BLK_W-1:0] blk,
                               input logic [lpba_pkg::LEN_W-1:0] len, input bit typed,
                               input alloc_t typed_res);
    alloc_t predicted;
    int     gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {len, blk, tbl};
    do @(posedge clk); while (!in_tready);
    predicted = allocate_page(tbl, blk, len);
    owe_result(typed ? typed_res : predicted);
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait for every owed result; always advances at least one edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_allocs.size() != 0);
  endtask

  // One-cycle register write; the model register follows at the same edge.
  task automatic write_reg(input logic [lpba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lpba_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lpba_pkg::CFG_PAGE_SIZE) page_size_q = val[lpba_pkg::PSIZE_W-1:0];
    else                                pool_size_q = val[lpba_pkg::PIU_W-1:0];
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic plan_row_t cfg_row(logic [lpba_pkg::CFG_IDX_W-1:0] idx,
                                        logic [lpba_pkg::CFG_W-1:0] val);
    plan_row_t r;
    r.is_cfg = 1'b1;  r.idx = idx;  r.val = val;
    r.tbl = '0;  r.blk = '0;  r.len = '0;
    r.typed = 1'b0;  r.res.status = lpba_pkg::STAT_FREE;  r.res.page = '0;
    return r;
  endfunction

  function automatic plan_row_t chk_row(logic [lpba_pkg::TBL_W-1:0] tbl,
                                        logic [lpba_pkg::BLK_W-1:0] blk,
                                        logic [lpba_pkg::LEN_W-1:0] len,
                                        lpba_pkg::status_t st,
                                        logic [lpba_pkg::PAGE_W-1:0] pg);
    plan_row_t r;
    r.is_cfg = 1'b0;  r.idx = '0;  r.val = '0;
    r.tbl = tbl;  r.blk = blk;  r.len = len;
    r.typed = 1'b1;  r.res.status = st;  r.res.page = pg;
    return r;
  endfunction

  function automatic plan_row_t req_row(logic [lpba_pkg::TBL_W-1:0] tbl,
                                        logic [lpba_pkg::BLK_W-1:0] blk,
                                        logic [lpba_pkg::LEN_W-1:0] len);
    plan_row_t r;
    r       = chk_row(tbl, blk, len, lpba_pkg::STAT_FREE, '0);
    r.typed = 1'b0;
    return r;
  endfunction

  plan_row_t directed_plan[$];

  // ---------------------------------------------------------------------------
  // Result side: stall pattern that cycles through modes, with periodic long hold-offs
  // so the single result register fills and the block stops taking requests.
  // ---------------------------------------------------------------------------
  int rx_cycles = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    rx_cycles++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rx_cycles % 6000 == 2000) begin
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      case ((rx_cycles / 800) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 9) < 3);
        default: out_tready <= ((rx_cycles % 5) < 2);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest owed one.
  // ---------------------------------------------------------------------------
  int     mismatch_count = 0;
  int     status_tally[4];
  alloc_t want;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_allocs.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed, data 0x%02h", out_tdata));
      end else begin
        want = take_owed();
        status_tally[want.status]++;
        if (out_tdata[1:0] != want.status || out_tdata[5:2] != want.page)
          report_mismatch($sformatf("request %0d: want status %0d page %0d, got %0d page %0d",
                                    sent_count - pending_allocs.size() - 1, want.status,
                                    want.page, out_tdata[1:0], out_tdata[5:2]));
      end
    end
  end

  // Watchdog: end the run if neither side moves anything for too long.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results owed",
                 STUCK_LIMIT, pending_allocs.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [lpba_pkg::TBL_W-1:0]   pool_tbl [TAG_POOL];
  logic [lpba_pkg::BLK_W-1:0]   pool_blk [TAG_POOL];

  initial begin
    logic [lpba_pkg::PSIZE_W-1:0] ps;
    logic [lpba_pkg::CFG_W-1:0]   piu_word;
    logic [lpba_pkg::TBL_W-1:0]   tbl;
    logic [lpba_pkg::BLK_W-1:0]   blk;
    logic [lpba_pkg::LEN_W-1:0]   len;
    int                           k;
    int                           sel;

    // Model state after reset: empty pool, default registers.
    page_size_q = lpba_pkg::PAGE_SIZE_RST;
    pool_size_q = lpba_pkg::PAGES_IN_USE_RST;
    pages_taken = 0;
    foreach (status_tally[i]) status_tally[i] = 0;

    // Directed part. Typed rows can be read straight off the LRU rules.
    directed_plan.insert(directed_plan.size(),
      chk_row(8'h00, 32'h0000_0000, 16'd0,    lpba_pkg::STAT_FREE,     4'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'h00, 32'h0000_0000, 16'd1024, lpba_pkg::STAT_HIT,      4'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'h00, 32'h0000_0000, 16'd1025, lpba_pkg::STAT_TOO_LONG, 4'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, lpba_pkg::STAT_TOO_LONG, 4'd0));
    // Pool size zero acts as a single page: misses recycle page 0.
    directed_plan.insert(directed_plan.size(), cfg_row(lpba_pkg::CFG_PAGES_IN_USE, 16'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'hFF, 32'hFFFF_FFFF, 16'd0,    lpba_pkg::STAT_REPLACED, 4'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'hFF, 32'hFFFF_FFFF, 16'd1,    lpba_pkg::STAT_HIT,      4'd0));
    // Zero page size: only empty content gets through.
    directed_plan.insert(directed_plan.size(), cfg_row(lpba_pkg::CFG_PAGE_SIZE, 16'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'hFF, 32'hFFFF_FFFF, 16'd1,    lpba_pkg::STAT_TOO_LONG, 4'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'hFF, 32'hFFFF_FFFF, 16'd0,    lpba_pkg::STAT_HIT,      4'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'h00, 32'h0000_0000, 16'd0,    lpba_pkg::STAT_REPLACED, 4'd0));
    // Two-page pool with the largest page size.
    directed_plan.insert(directed_plan.size(), cfg_row(lpba_pkg::CFG_PAGE_SIZE, 16'hFFFF));
    directed_plan.insert(directed_plan.size(), cfg_row(lpba_pkg::CFG_PAGES_IN_USE, 16'd2));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'hAA, 32'h5555_5555, 16'hFFFF, lpba_pkg::STAT_FREE,     4'd1));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'h00, 32'h0000_0000, 16'd0,    lpba_pkg::STAT_HIT,      4'd0));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'h55, 32'hAAAA_AAAA, 16'd0,    lpba_pkg::STAT_REPLACED, 4'd1));
    // Oversize pool value (all ones, upper data bits set) acts as the full pool.
    directed_plan.insert(directed_plan.size(), cfg_row(lpba_pkg::CFG_PAGES_IN_USE, 16'hFFFF));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'h01, 32'h0000_0000, 16'd0,    lpba_pkg::STAT_FREE,     4'd2));
    directed_plan.insert(directed_plan.size(),
      chk_row(8'h00, 32'h0000_0001, 16'd0,    lpba_pkg::STAT_FREE,     4'd3));
    directed_plan.insert(directed_plan.size(), req_row(8'h55, 32'hAAAA_AAAA, 16'd7));
    directed_plan.insert(directed_plan.size(), req_row(8'hAA, 32'h5555_5555, 16'd8));
    directed_plan.insert(directed_plan.size(), req_row(8'h3C, 32'h0F0F_0F0F, 16'd300));

    // Hold reset, then release it once for the rest of the run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        drain();
        write_reg(directed_plan[i].idx, directed_plan[i].val);
      end else begin
        offer_request(directed_plan[i].tbl, directed_plan[i].blk, directed_plan[i].len,
                      directed_plan[i].typed, directed_plan[i].res);
      end
    end

    // Random phases: each one picks a register setting, then mostly reuses a small
    // set of tags so hits, recency reordering and LRU eviction all get exercised.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin ps = lpba_pkg::PAGE_SIZE_RST;   piu_word = 16'd16; end
        1: begin ps = 16'hFFFF;                  piu_word = 16'd31; end
        2: begin ps = 16'd0;                     piu_word = 16'd0;  end
        3: begin ps = 16'd1;                     piu_word = 16'd3;  end
        4: begin ps = 16'($urandom);             piu_word = 16'($urandom_range(0, 31)); end
        5: begin ps = 16'($urandom_range(1, 2048)); piu_word = 16'd16; end
        6: begin ps = lpba_pkg::PAGE_SIZE_RST;   piu_word = 16'd8;  end
        default: begin ps = 16'($urandom_range(0, 64)); piu_word = 16'($urandom_range(1, 16)); end
      endcase
      // Toggle the unused upper bits of the pool-size word on odd phases.
      if (ph % 2 == 1) piu_word = (16'($urandom) & 16'hFFE0) | piu_word;
      gap_max = (ph % 3 == 2) ? 0 : 6;   // some phases run back to back

      drain();
      write_reg(lpba_pkg::CFG_PAGE_SIZE, ps);
      drain();
      write_reg(lpba_pkg::CFG_PAGES_IN_USE, piu_word);

      // Refresh part of the tag set; small values make near-miss tags likely.
      for (int i = 0; i < TAG_POOL; i++) begin
        if (ph == 0 || $urandom_range(0, 1) == 1) begin
          pool_tbl[i] = ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
          pool_blk[i] = ($urandom_range(0, 1) == 1) ? $urandom : 32'($urandom_range(0, 7));
        end
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          k   = $urandom_range(0, TAG_POOL - 1);
          tbl = pool_tbl[k];
          blk = pool_blk[k];
        end else begin
          tbl = 8'($urandom);
          blk = $urandom;
        end
        // Lengths cluster on the limit and its neighbors; most stay acceptable.
        sel = $urandom_range(0, 99);
        if (sel < 15)                           len = '0;
        else if (sel < 30)                      len = page_size_q;
        else if (sel < 40)                      len = page_size_q + 16'd1;
        else if (sel < 45)                      len = 16'hFFFF;
        else if (sel < 50 || page_size_q == 0)  len = 16'($urandom);
        else                                    len = 16'($urandom_range(0, page_size_q));
        offer_request(tbl, blk, len, 1'b0, '0);
      end
    end

    // Wait out every owed result, then a margin for anything stray.
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d requests: %0d free, %0d replaced, %0d hits, %0d too long",
             sent_count, status_tally[lpba_pkg::STAT_FREE],
             status_tally[lpba_pkg::STAT_REPLACED],
             status_tally[lpba_pkg::STAT_HIT], status_tally[lpba_pkg::STAT_TOO_LONG]);
    $display("Made %0d register writes incl. zero and full page size, pools 0 to 31; %0d bad",
             cfg_writes, mismatch_count);
    if (mismatch_count == 0 && pending_allocs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[lru_page_buffer_allocator.f]
+incdir+design
design/lpba_pkg.sv
design/lpba_tag_store.sv
design/lpba_recency.sv
design/lru_page_buffer_allocator.sv
verif/testbench.sv
